FILE: rtl/swr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the sample_without_replacement block.
// Holds the sequencer state type, opcodes, status codes and register indexes.
// No dependencies.
package swr_pkg;

  // Operation codes carried by the op field
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANK_HIGH = 2'd1;
  localparam logic [1:0] ST_NO_DRAWS  = 2'd2;
  localparam logic [1:0] ST_NONE_LEFT = 2'd3;

  // Configuration register indexes
  localparam logic REG_RANGE_SIZE   = 1'b0;
  localparam logic REG_DRAWS_WANTED = 1'b1;

  // Most results a list transaction may produce
  localparam logic [6:0] LIST_CAP = 7'd64;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,  // sweep the map after reset
    S_IDLE  = 7'b0000010,  // wait for an input transaction
    S_CLEAR = 7'b0000100,  // sweep the map for a clear
    S_RD    = 7'b0001000,  // issue a map read
    S_CHK   = 7'b0010000,  // examine the read mark
    S_FLUSH = 7'b0100000,  // finish a list
    S_EMIT  = 7'b1000000   // deliver a single result
  } state_e;

endpackage : swr_pkg
`default_nettype wire

FILE: rtl/sample_without_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the sampling-without-replacement block: used-mark memory,
// scan sequencer, configuration registers and output register.
// Depends on swr_pkg.

// Keeps a used mark for each integer 0 .. m-1 (m = range_size, capped at
// RANGE_MAX) in a one-bit-wide memory with a registered read port. One scan
// sequencer walks the memory entry by entry (read, then check); a list can
// wait at the check while the output register is full and stalled. A draw
// that is refused for lack of draws goes straight to its report. A clear
// sweeps all RANGE_MAX entries, one per cycle, then reports. After reset the
// same sweep runs before the first input transaction is taken; configuration
// writes are taken at any time. The block works on one transaction at a
// time and holds in_stall_o high meanwhile; the output register lets a new
// input be taken while the last result still waits.
module sample_without_replacement #(
  parameter int unsigned RANGE_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [5:0] rank_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      value_o,
  output logic [1:0]      status_o,
  output logic            last_o,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [6:0] cfg_data_i
);
  import swr_pkg::*;

  localparam int unsigned AW = $clog2(RANGE_MAX);
  localparam int unsigned MW = $clog2(RANGE_MAX + 1);
  localparam int unsigned CW = (MW > 7) ? MW : 7;
  localparam logic [MW-1:0] SWEEP_END = MW'(RANGE_MAX - 1);
  localparam logic [CW-1:0] SPAN_MAX  = CW'(RANGE_MAX);

  // Configuration registers
  logic [6:0] range_q;
  logic [6:0] wanted_q;

  // Sequencer and scan state
  state_e      state_q, state_d;
  logic [MW-1:0] scan_q, scan_d;
  logic [5:0]  seen_q, seen_d;
  logic [5:0]  rank_q, rank_d;
  logic [1:0]  op_q, op_d;
  logic [6:0]  draw_cnt_q, draw_cnt_d;
  logic [AW-1:0] pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;
  logic [6:0]  found_q, found_d;
  logic [5:0]  res_value_q, res_value_d;
  logic [1:0]  res_status_q, res_status_d;

  // Output register
  logic        out_vld_q, out_vld_d;
  logic [5:0]  out_value_q, out_value_d;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_last_q, out_last_d;

  // Mark memory
  logic          mark_mem [RANGE_MAX];
  logic          mark_rd_q;
  logic          mark_we;
  logic          mark_wdata;
  logic [AW-1:0] mark_addr;

  // Helpers
  logic [CW-1:0] span;
  logic [CW-1:0] range_ext;
  logic          in_accept;
  logic          out_free;
  logic [AW+5:0] scan_wide;
  logic [AW+5:0] pend_wide;
  logic [5:0]    scan_val;
  logic [5:0]    pend_val;
  logic [6:0]    found_inc;

  assign range_ext = CW'(range_q);
  assign span      = (range_ext > SPAN_MAX) ? SPAN_MAX : range_ext;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_vld_q || !out_stall_i;
  assign mark_addr = scan_q[AW-1:0];
  assign scan_wide = {6'd0, scan_q[AW-1:0]};
  assign pend_wide = {6'd0, pend_q};
  assign scan_val  = scan_wide[5:0];
  assign pend_val  = pend_wide[5:0];
  assign found_inc = found_q + 7'd1;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= 7'd64;
      wanted_q <= 7'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RANGE_SIZE:   range_q  <= cfg_data_i;
        REG_DRAWS_WANTED: wanted_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    seen_d       = seen_q;
    rank_d       = rank_q;
    op_d         = op_q;
    draw_cnt_d   = draw_cnt_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    found_d      = found_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    mark_we      = 1'b0;
    mark_wdata   = 1'b0;

    case (state_q)
      S_INIT: begin
        // clear one entry per cycle
        mark_we = 1'b1;
        scan_d  = scan_q + MW'(1);
        if (scan_q == SWEEP_END) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          op_d       = op_i;
          rank_d     = rank_i;
          scan_d     = '0;
          seen_d     = '0;
          pend_vld_d = 1'b0;
          found_d    = '0;
          case (op_i)
            OP_CLEAR: begin
              state_d = S_CLEAR;
            end
            OP_DRAW: begin
              if (draw_cnt_q >= wanted_q || CW'(draw_cnt_q) >= span) begin
                res_value_d  = '0;
                res_status_d = ST_NO_DRAWS;
                state_d      = S_EMIT;
              end else begin
                state_d = S_RD;
              end
            end
            OP_LIST: begin
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_CLEAR: begin
        // sweep the whole map, then report
        mark_we = 1'b1;
        scan_d  = scan_q + MW'(1);
        if (scan_q == SWEEP_END) begin
          draw_cnt_d   = '0;
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_EMIT;
        end
      end

      S_RD: begin
        // end of the range, or fetch the next mark
        if (CW'(scan_q) >= span) begin
          if (op_q == OP_LIST) begin
            state_d = S_FLUSH;
          end else begin
            res_value_d  = '0;
            res_status_d = ST_RANK_HIGH;
            state_d      = S_EMIT;
          end
        end else begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if (mark_rd_q) begin
          scan_d  = scan_q + MW'(1);
          state_d = S_RD;
        end else if (op_q == OP_DRAW) begin
          if (seen_q == rank_q) begin
            // take this entry
            mark_we      = 1'b1;
            mark_wdata   = 1'b1;
            draw_cnt_d   = draw_cnt_q + 7'd1;
            res_value_d  = scan_val;
            res_status_d = ST_OK;
            state_d      = S_EMIT;
          end else begin
            seen_d  = seen_q + 6'd1;
            scan_d  = scan_q + MW'(1);
            state_d = S_RD;
          end
        end else if (!pend_vld_q || out_free) begin
          // list: push the held entry out, hold the new one
          if (pend_vld_q) begin
            out_vld_d    = 1'b1;
            out_value_d  = pend_val;
            out_status_d = ST_OK;
            out_last_d   = 1'b0;
          end
          pend_d     = scan_q[AW-1:0];
          pend_vld_d = 1'b1;
          found_d    = found_inc;
          scan_d     = scan_q + MW'(1);
          state_d    = (found_inc == LIST_CAP) ? S_FLUSH : S_RD;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_last_d   = 1'b1;
          out_value_d  = pend_vld_q ? pend_val : 6'd0;
          out_status_d = pend_vld_q ? ST_OK : ST_NONE_LEFT;
          state_d      = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_last_d   = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      scan_q     <= '0;
      draw_cnt_q <= '0;
      pend_vld_q <= 1'b0;
      found_q    <= '0;
      seen_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      draw_cnt_q <= draw_cnt_d;
      pend_vld_q <= pend_vld_d;
      found_q    <= found_d;
      seen_q     <= seen_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rank_q       <= rank_d;
    op_q         <= op_d;
    pend_q       <= pend_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  // Mark memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[mark_addr];
  end

endmodule : sample_without_replacement
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_without_replacement: clears, draws and
// lists are checked against a bitmap predictor, with random input gaps and output stalls.
// Depends on swr_pkg and the sample_without_replacement RTL.
module testbench;
  import swr_pkg::*;

  localparam logic [1:0]  OP_IGNORED    = 2'd3;
  localparam int unsigned MAP_SIZE      = 64;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 28;

  typedef struct packed {
    logic [5:0] value;
    logic [1:0] status;
    logic       last;
  } pick_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] op_i;
  logic [5:0] rank_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [5:0] value_o;
  logic [1:0] status_o;
  logic       last_o;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [6:0] cfg_data_i;

  // Predictor state: used marks, draws since clear, register copies
  logic       mark_used [MAP_SIZE];
  logic [6:0] draws_made;
  logic [6:0] cfg_range;
  logic [6:0] cfg_draws;
  pick_t      expected_picks [$];
  pick_t      want_pick;
  int unsigned error_count;

  // Idling controls
  bit          steady_mode;
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stall_run;
  int unsigned stall_roll;

  sample_without_replacement dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic pick_t make_pick(input logic [5:0] value, input logic [1:0] status,
                                      input logic last);
    pick_t p;
    p.value  = value;
    p.status = status;
    p.last   = last;
    return p;
  endfunction

  // Range size capped at the map size
  function automatic int unsigned live_span();
    return (cfg_range > MAP_SIZE) ? MAP_SIZE : int'(cfg_range);
  endfunction

  function automatic int unsigned free_count();
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < live_span(); i++) begin
      if (!mark_used[i]) n++;
    end
    return n;
  endfunction

  function automatic bit draws_spent();
    return (draws_made >= cfg_draws) || (draws_made >= live_span());
  endfunction

  // Work out the results of one accepted transaction and update the map
  function automatic void predict_picks(input logic [1:0] op, input logic [5:0] rank);
    int unsigned m;
    int unsigned free;
    int unsigned seen;
    int unsigned total;
    int unsigned k;
    m    = live_span();
    free = free_count();
    case (op)
      OP_CLEAR: begin
        foreach (mark_used[i]) mark_used[i] = 1'b0;
        draws_made = '0;
        expected_picks.push_back(make_pick(6'd0, ST_OK, 1'b1));
      end
      OP_DRAW: begin
        if (draws_spent()) begin
          expected_picks.push_back(make_pick(6'd0, ST_NO_DRAWS, 1'b1));
        end else if (rank >= free) begin
          expected_picks.push_back(make_pick(6'd0, ST_RANK_HIGH, 1'b1));
        end else begin
          seen = 0;
          for (int unsigned i = 0; i < m; i++) begin
            if (!mark_used[i]) begin
              if (seen == rank) begin
                mark_used[i] = 1'b1;
                draws_made = draws_made + 7'd1;
                expected_picks.push_back(make_pick(6'(i), ST_OK, 1'b1));
                break;
              end
              seen++;
            end
          end
        end
      end
      OP_LIST: begin
        total = (free > LIST_CAP) ? int'(LIST_CAP) : free;
        if (total == 0) begin
          expected_picks.push_back(make_pick(6'd0, ST_NONE_LEFT, 1'b1));
        end else begin
          k = 0;
          for (int unsigned i = 0; i < m && k < total; i++) begin
            if (!mark_used[i]) begin
              expected_picks.push_back(make_pick(6'(i), ST_OK, k == total - 1));
              k++;
            end
          end
        end
      end
      default: ;  // unknown op: no results, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: value %0d status %0d last %0d",
               value_o, status_o, last_o);
        error_count++;
      end else begin
        want_pick = expected_picks.pop_front();
        if (value_o !== want_pick.value) begin
          $error("value: expected %0d, got %0d", want_pick.value, value_o);
          error_count++;
        end
        if (status_o !== want_pick.status) begin
          $error("status: expected %0d, got %0d", want_pick.status, status_o);
          error_count++;
        end
        if (last_o !== want_pick.last) begin
          $error("last: expected %0d, got %0d", want_pick.last, last_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall the result channel: mostly short runs, a few long, and long hold-offs
  initial begin
    out_stall_i = 1'b0;
    hold_seen   = 0;
    hold_left   = 0;
    stall_run   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (steady_mode) begin
        out_stall_i = 1'b0;
      end else if (stall_run != 0) begin
        stall_run--;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 60) begin
          out_stall_i = 1'b0;
          stall_run   = $urandom_range(0, 8);
        end else if (stall_roll < 95) begin
          out_stall_i = 1'b1;
          stall_run   = $urandom_range(0, 3);
        end else begin
          out_stall_i = 1'b1;
          stall_run   = $urandom_range(10, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one input transaction, wait for it to be taken, then predict it
  task automatic send_item(input logic [1:0] op, input logic [5:0] rank);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    rank_i     = rank;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_picks(op, rank);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [6:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (index == REG_RANGE_SIZE) cfg_range = data;
    else                         cfg_draws = data;
  endtask

  task automatic set_config(input logic [6:0] range_size, input logic [6:0] draws_wanted);
    wait_drained();
    write_reg(REG_RANGE_SIZE, range_size);
    write_reg(REG_DRAWS_WANTED, draws_wanted);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values: no draws allowed, full map of 64 unused
  task automatic test_reset_state();
    send_item(OP_DRAW, 6'd0);
    send_item(OP_LIST, 6'd0);
    send_item(OP_IGNORED, 6'd63);
    send_item(OP_CLEAR, 6'd0);
  endtask

  // Extreme ranks, a rank just past the unused count, then a long list
  task automatic test_draw_extremes();
    set_config(7'd64, 7'd64);
    send_item(OP_DRAW, 6'd63);
    send_item(OP_DRAW, 6'd0);
    send_item(OP_DRAW, 6'd62);
    send_item(OP_DRAW, 6'd61);
    send_item(OP_LIST, 6'd63);
  endtask

  // Shrink the range over existing marks, then widen past the map
  task automatic test_range_changes();
    set_config(7'd10, 7'd64);
    send_item(OP_LIST, 6'd0);
    send_item(OP_DRAW, 6'd9);
    set_config(7'd127, 7'd127);
    send_item(OP_LIST, 6'd0);
    send_item(OP_CLEAR, 6'd0);
  endtask

  // Tiny and empty ranges: exhausted draws and lists with nothing unused
  task automatic test_tiny_ranges();
    set_config(7'd1, 7'd1);
    send_item(OP_DRAW, 6'd0);
    send_item(OP_DRAW, 6'd0);
    send_item(OP_LIST, 6'd0);
    set_config(7'd0, 7'd5);
    send_item(OP_DRAW, 6'd0);
    send_item(OP_LIST, 6'd0);
    set_config(7'd2, 7'd64);
    send_item(OP_CLEAR, 6'd0);
    send_item(OP_DRAW, 6'd1);
    send_item(OP_DRAW, 6'd0);
    send_item(OP_DRAW, 6'd0);
  endtask

  // One random transaction: mostly well-formed draws, some lists and noise
  task automatic send_random_item(inout int unsigned counted);
    int unsigned r;
    int unsigned free;
    logic [1:0]  op;
    logic [5:0]  rank;
    r    = $urandom_range(0, 99);
    rank = 6'($urandom_range(0, 63));
    if (r < 6 || (draws_spent() && r < 40)) begin
      op = OP_CLEAR;
    end else if (r < 16) begin
      op = OP_LIST;
    end else if (r < 80) begin
      op   = OP_DRAW;
      free = free_count();
      if (free != 0) rank = 6'($urandom_range(0, free - 1));
    end else if (r < 95) begin
      op = OP_DRAW;
    end else begin
      op = (r < 98) ? OP_IGNORED : OP_CLEAR;
    end
    send_item(op, rank);
    if (op != OP_IGNORED) counted++;
  endtask

  // Random phases over several register settings, one of them without idling
  task automatic test_random_phases();
    int unsigned counted;
    logic [6:0]  range_size;
    logic [6:0]  draws_wanted;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin range_size = 7'd64;  draws_wanted = 7'd64;  end
        1:       begin range_size = 7'd127; draws_wanted = 7'd127; end
        2:       begin range_size = 7'd64;  draws_wanted = 7'd0;   end
        3:       begin range_size = 7'd3;   draws_wanted = 7'd2;   end
        default: begin
          range_size   = 7'($urandom_range(1, 64));
          draws_wanted = 7'($urandom_range(0, int'(range_size) + 3));
        end
      endcase
      set_config(range_size, draws_wanted);
      steady_mode = (p == 4);
      send_item(OP_CLEAR, 6'd0);
      counted = 1;
      while (counted < PHASE_ITEMS) send_random_item(counted);
      steady_mode = 1'b0;
    end
  endtask

  // Hold off the receiver while the sender keeps offering, so the block fills
  task automatic test_backpressure();
    int unsigned counted;
    set_config(7'd64, 7'd64);
    send_item(OP_CLEAR, 6'd0);
    hold_seq++;
    send_item(OP_LIST, 6'd0);
    counted = 0;
    while (counted < 8) send_random_item(counted);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_CLEAR;
    rank_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_RANGE_SIZE;
    cfg_data_i  = '0;
    steady_mode = 1'b0;
    hold_seq    = 0;
    error_count = 0;
    foreach (mark_used[i]) mark_used[i] = 1'b0;
    draws_made = '0;
    cfg_range  = 7'd64;
    cfg_draws  = 7'd0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_draw_extremes();
    test_range_changes();
    test_tiny_ranges();
    test_backpressure();
    test_random_phases();
    wait_drained();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/swr_pkg.sv
rtl/sample_without_replacement.sv
verif/testbench.sv
